[hdl/assert_macros.svh]
// Assertion macros shared by the bad pixel correction RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define BBPM_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("bbpm assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define BBPM_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("bbpm assertion failed");

`endif

[hdl/bbpm_pkg.sv]
// Types, constants and sorting functions of the Bayer bad pixel median correction.
`default_nettype none

package bbpm_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int PIXEL_BITS = 16;
  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int WID_BITS   = 13;
  localparam int HGT_BITS   = 15;
  localparam int ROW_BITS   = 15;
  localparam int ENTRY_BITS = PIXEL_BITS + 1;
  localparam int MEM_BITS   = 4 * ENTRY_BITS;
  localparam int CFG_BITS   = 15;

  localparam logic [WID_BITS-1:0] WIDTH_MIN    = WID_BITS'(5);
  localparam logic [WID_BITS-1:0] WIDTH_MAX    = WID_BITS'(MAX_WIDTH);
  localparam logic [WID_BITS-1:0] WIDTH_RESET  = WID_BITS'(4096);
  localparam logic [HGT_BITS-1:0] HEIGHT_MIN   = HGT_BITS'(5);
  localparam logic [HGT_BITS-1:0] HEIGHT_MAX   = HGT_BITS'(16384);
  localparam logic [HGT_BITS-1:0] HEIGHT_RESET = HGT_BITS'(1024);

  // register indexes of the configuration port
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_ORDER  = 2'd2;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // window places of the median candidates: green uses the first four
  localparam logic [2:0] GRN_ROW [4] = '{3'd1, 3'd1, 3'd3, 3'd3};
  localparam logic [2:0] GRN_COL [4] = '{3'd1, 3'd3, 3'd1, 3'd3};
  localparam logic [2:0] RB_ROW  [8] = '{3'd0, 3'd0, 3'd0, 3'd2, 3'd2, 3'd4, 3'd4, 3'd4};
  localparam logic [2:0] RB_COL  [8] = '{3'd0, 3'd2, 3'd4, 3'd0, 3'd4, 3'd0, 3'd2, 3'd4};

  typedef struct packed {
    logic                  operation;
    logic [PIXEL_BITS-1:0] pixel_value;
    logic                  is_bad;
  } in_item_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] corrected_value;
    logic                  was_replaced;
    logic                  frame_end;
  } out_item_t;

  // sort key: invalid flag above the value, so invalid entries sort last
  typedef logic [ENTRY_BITS-1:0] key_t;
  typedef key_t [7:0] key_vec_t;

  typedef struct packed {
    key_vec_t              keys;
    logic [3:0]            count;
    logic                  replace_en;
    logic [PIXEL_BITS-1:0] centre;
    logic                  last;
  } med_in_t;

  function automatic key_vec_t cmp_swap(key_vec_t a, logic [2:0] i, logic [2:0] j);
    key_vec_t r;
    r = a;
    if (a[i] > a[j]) begin
      r[i] = a[j];
      r[j] = a[i];
    end
    return r;
  endfunction

  // first three layers of the odd-even merge network
  function automatic key_vec_t sort_front(key_vec_t a);
    key_vec_t r;
    r = a;
    r = cmp_swap(r, 3'd0, 3'd1);
    r = cmp_swap(r, 3'd2, 3'd3);
    r = cmp_swap(r, 3'd4, 3'd5);
    r = cmp_swap(r, 3'd6, 3'd7);
    r = cmp_swap(r, 3'd0, 3'd2);
    r = cmp_swap(r, 3'd1, 3'd3);
    r = cmp_swap(r, 3'd4, 3'd6);
    r = cmp_swap(r, 3'd5, 3'd7);
    r = cmp_swap(r, 3'd1, 3'd2);
    r = cmp_swap(r, 3'd5, 3'd6);
    return r;
  endfunction

  // last three layers
  function automatic key_vec_t sort_back(key_vec_t a);
    key_vec_t r;
    r = a;
    r = cmp_swap(r, 3'd0, 3'd4);
    r = cmp_swap(r, 3'd1, 3'd5);
    r = cmp_swap(r, 3'd2, 3'd6);
    r = cmp_swap(r, 3'd3, 3'd7);
    r = cmp_swap(r, 3'd2, 3'd4);
    r = cmp_swap(r, 3'd3, 3'd5);
    r = cmp_swap(r, 3'd1, 3'd2);
    r = cmp_swap(r, 3'd3, 3'd4);
    r = cmp_swap(r, 3'd5, 3'd6);
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/bayer_bad_pixel_median_correct_unit.sv]
// Top level: raster counters, line memory, 5x5 window and median correction.
//
//  port group  | dir | handshake             | beat
//  ------------+-----+-----------------------+----------------------------------
//  in_*        | in  | in_valid / in_ready   | operation, pixel_value, is_bad
//  out_*       | out | out_valid / out_ready | corrected_value, was_replaced, frame_end
//  cfg_*       | in  | cfg_we                | frame_width, frame_height, bayer_order
//
// One beat per cycle in and out while out_ready does not stall; seven register stages
// from the input register to the output register, among them the line memory read
// stage, the window stage and the six-layer sorting network split over two stages.
// A result leaves 2*width+2 raster positions after its pixel; flush beats drain.
// rst is synchronous and clears control state; the line memory needs no clearing.
// Each stage moves when its successor has room, so bubbles close up under stall.
`default_nettype none
`include "assert_macros.svh"

module bayer_bad_pixel_median_correct_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire bbpm_pkg::in_item_t                  in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output bbpm_pkg::out_item_t                      out_data,
  input  wire logic                                cfg_we,
  input  wire logic [1:0]                          cfg_index,
  input  wire logic [bbpm_pkg::CFG_BITS-1:0]       cfg_data
);

  localparam int EB = bbpm_pkg::ENTRY_BITS;
  localparam int CB = bbpm_pkg::COL_BITS;
  localparam int WB = bbpm_pkg::WID_BITS;
  localparam int HB = bbpm_pkg::HGT_BITS;
  localparam int RB = bbpm_pkg::ROW_BITS;

  typedef struct packed {
    logic [CB-1:0] addr;
    logic [EB-1:0] entry;
    logic          emit;
    logic          last;
    logic          green;
    logic [4:0]    colok;
    logic [4:0]    rowok;
  } s_ctl_t;

  // configuration registers
  logic [WB-1:0] frame_width;
  logic [HB-1:0] frame_height;
  logic [1:0]    bayer_order;
  logic [WB-1:0] w_eff;
  logic [HB-1:0] h_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bbpm_pkg::WIDTH_RESET;
      frame_height <= bbpm_pkg::HEIGHT_RESET;
      bayer_order  <= 2'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bbpm_pkg::CFG_WIDTH:  frame_width  <= cfg_data[WB-1:0];
        bbpm_pkg::CFG_HEIGHT: frame_height <= cfg_data[HB-1:0];
        bbpm_pkg::CFG_ORDER:  bayer_order  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = frame_width;
    if (frame_width < bbpm_pkg::WIDTH_MIN) w_eff = bbpm_pkg::WIDTH_MIN;
    if (frame_width > bbpm_pkg::WIDTH_MAX) w_eff = bbpm_pkg::WIDTH_MAX;
    h_eff = frame_height;
    if (frame_height < bbpm_pkg::HEIGHT_MIN) h_eff = bbpm_pkg::HEIGHT_MIN;
    if (frame_height > bbpm_pkg::HEIGHT_MAX) h_eff = bbpm_pkg::HEIGHT_MAX;
  end

  // raster counters
  logic [CB-1:0] in_col, out_col, in_col_next, out_col_next;
  logic [RB-1:0] in_row, out_row, in_row_next, out_row_next;
  logic          in_frame, take, emit_now, last_now, accept;
  logic [WB:0]   cx;
  logic [RB:0]   cy;
  s_ctl_t        s1_next;

  logic          v1, v2, v3, en1, en2, en3;
  s_ctl_t        s1, s2, s3;
  logic [bbpm_pkg::MEM_BITS-1:0] rd_q;
  logic          med_ready;

  assign accept   = in_valid && in_ready;
  assign in_frame = in_row < RB'(h_eff);
  assign take     = !(in_frame && in_data.operation == bbpm_pkg::OP_FLUSH);
  assign emit_now = (in_row > RB'(2)) || (in_row == RB'(2) && in_col >= CB'(2));
  assign cx       = {2'b00, out_col};
  assign cy       = {1'b0, out_row};
  assign last_now = (out_row >= RB'(h_eff)) ||
                    (out_row == RB'(h_eff - HB'(1)) && cx + (WB+1)'(1) >= {1'b0, w_eff});

  always_comb begin
    in_col_next  = in_col + CB'(1);
    in_row_next  = in_row;
    if ({1'b0, in_col} + WB'(1) >= w_eff) begin
      in_col_next = '0;
      in_row_next = in_row + RB'(1);
    end
    out_col_next = out_col + CB'(1);
    out_row_next = out_row;
    if (cx + (WB+1)'(1) >= {1'b0, w_eff}) begin
      out_col_next = '0;
      out_row_next = out_row + RB'(1);
    end
    if (emit_now && last_now) begin
      in_col_next  = '0;
      in_row_next  = '0;
      out_col_next = '0;
      out_row_next = '0;
    end else if (!emit_now) begin
      out_col_next = out_col;
      out_row_next = out_row;
    end

    s1_next.addr  = in_col;
    s1_next.entry = in_frame ? {in_data.is_bad, in_data.pixel_value} : '0;
    s1_next.emit  = emit_now;
    s1_next.last  = last_now;
    s1_next.green = (out_col[0] ^ out_row[0]) == bayer_order[1];
    s1_next.colok[0] = (cx >= (WB+1)'(2)) && (cx - (WB+1)'(2) < {1'b0, w_eff});
    s1_next.colok[1] = (cx >= (WB+1)'(1)) && (cx - (WB+1)'(1) < {1'b0, w_eff});
    s1_next.colok[2] = cx < {1'b0, w_eff};
    s1_next.colok[3] = cx + (WB+1)'(1) < {1'b0, w_eff};
    s1_next.colok[4] = cx + (WB+1)'(2) < {1'b0, w_eff};
    s1_next.rowok[0] = (cy >= (RB+1)'(2)) && (cy - (RB+1)'(2) < {1'b0, h_eff});
    s1_next.rowok[1] = (cy >= (RB+1)'(1)) && (cy - (RB+1)'(1) < {1'b0, h_eff});
    s1_next.rowok[2] = cy < {1'b0, h_eff};
    s1_next.rowok[3] = cy + (RB+1)'(1) < {1'b0, h_eff};
    s1_next.rowok[4] = cy + (RB+1)'(2) < {1'b0, h_eff};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (accept && take) begin
      in_col  <= in_col_next;
      in_row  <= in_row_next;
      out_col <= out_col_next;
      out_row <= out_row_next;
    end
  end

  // pipeline control
  assign en3      = !v3 || !s3.emit || med_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid && take;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  // line memory: one word per column holds the four rows above
  logic [bbpm_pkg::MEM_BITS-1:0] line_mem [bbpm_pkg::MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (en2) rd_q <= line_mem[s1.addr];
    if (v2 && en3) line_mem[s2.addr] <= {rd_q[3*EB-1:0], s2.entry};
  end

  // 5x5 window, row 0 oldest, column 4 newest
  logic [EB-1:0] win [5][5];

  always_ff @(posedge clk) begin
    if (en1) s1 <= s1_next;
    if (en2) s2 <= s1;
    if (en3) begin
      s3 <= s2;
      if (v2) begin
        for (int r = 0; r < 5; r++) begin
          for (int c = 0; c < 4; c++) begin
            win[r][c] <= win[r][c+1];
          end
        end
        win[0][4] <= rd_q[4*EB-1:3*EB];
        win[1][4] <= rd_q[3*EB-1:2*EB];
        win[2][4] <= rd_q[2*EB-1:EB];
        win[3][4] <= rd_q[EB-1:0];
        win[4][4] <= s2.entry;
      end
    end
  end

  // pick candidates and build sort keys; drop the value of a rejected candidate
  bbpm_pkg::med_in_t med_in;

  always_comb begin
    logic [2:0]    r, c;
    logic          ok, ctr_in;
    logic [EB-1:0] nb;
    logic [3:0]    cnt;
    cnt    = '0;
    ctr_in = s3.rowok[2] && s3.colok[2];
    for (int i = 0; i < 8; i++) begin
      if (s3.green) begin
        r = bbpm_pkg::GRN_ROW[i % 4];
        c = bbpm_pkg::GRN_COL[i % 4];
      end else begin
        r = bbpm_pkg::RB_ROW[i];
        c = bbpm_pkg::RB_COL[i];
      end
      nb = win[r][c];
      ok = s3.rowok[r] && s3.colok[c] && !nb[EB-1] && (!s3.green || i < 4);
      med_in.keys[i] = {!ok, ok ? nb[EB-2:0] : {(EB-1){1'b0}}};
      cnt = cnt + {3'b000, ok};
    end
    med_in.count      = cnt;
    med_in.replace_en = ctr_in && win[2][2][EB-1];
    med_in.centre     = ctr_in ? win[2][2][EB-2:0] : '0;
    med_in.last       = s3.last;
  end

  bbpm_median u_median (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3 && s3.emit),
    .in_ready  (med_ready),
    .in_data   (med_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `BBPM_ASSERT_NXT(a_win_hold, v3 && !en3, v3 && $stable(s3))
  `BBPM_ASSERT_NXT(a_rd_hold, v2 && !en3, $stable(rd_q))
  `BBPM_ASSERT_NXT(a_frame_wrap, accept && take && emit_now && last_now,
                   in_col == '0 && in_row == '0 && out_col == '0 && out_row == '0)

endmodule

`default_nettype wire

[hdl/bbpm_median.sv]
// Pipelined eight-input sorting network that picks the upper median.
`default_nettype none
`include "assert_macros.svh"

module bbpm_median (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire bbpm_pkg::med_in_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output bbpm_pkg::out_item_t      out_data
);

  logic               va, vb, vc, vo;
  logic               en_a, en_b, en_c, en_o;
  bbpm_pkg::med_in_t  sa, sb, sc;
  bbpm_pkg::med_in_t  sb_next, sc_next;
  bbpm_pkg::out_item_t res;

  assign en_o     = !vo || out_ready;
  assign en_c     = !vc || en_o;
  assign en_b     = !vb || en_c;
  assign en_a     = !va || en_b;
  assign in_ready = en_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (en_a) va <= in_valid;
      if (en_b) vb <= va;
      if (en_c) vc <= vb;
      if (en_o) vo <= vc;
    end
  end

  always_comb begin
    sb_next      = sa;
    sb_next.keys = bbpm_pkg::sort_front(sa.keys);
    sc_next      = sb;
    sc_next.keys = bbpm_pkg::sort_back(sb.keys);
  end

  always_comb begin
    res.frame_end = sc.last;
    if (sc.replace_en && sc.count != 4'd0) begin
      res.corrected_value = sc.keys[sc.count[3:1]][bbpm_pkg::PIXEL_BITS-1:0];
      res.was_replaced    = 1'b1;
    end else begin
      res.corrected_value = sc.centre;
      res.was_replaced    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) sa <= in_data;
    if (en_b) sb <= sb_next;
    if (en_c) sc <= sc_next;
    if (en_o) out_data <= res;
  end

  assign out_valid = vo;

  `BBPM_ASSERT_NXT(a_sort_hold, vb && !en_b, vb && $stable(sb))
  `BBPM_ASSERT_NXT(a_sort_move, va && en_b, vb)
  `BBPM_ASSERT_IMP(a_repl_count, vc && sc.count == 4'd0, !res.was_replaced)

endmodule

`default_nettype wire
